### rtl/core/rgd_pkg.sv
// Shared constants and types for the rectangle gap distance block.
package rgd_pkg;

  // Queue between the gap front end and the square root back end.
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  // Queue occupancy flags seen by both neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/rgd_if.sv
// Valid/ready channel interfaces for rectangle pairs and gap results.
interface rgd_in_if #(
  parameter int unsigned COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_left;
  logic signed [COORD_BITS-1:0] first_top;
  logic        [COORD_BITS-2:0] first_extent_x;
  logic        [COORD_BITS-2:0] first_extent_y;
  logic signed [COORD_BITS-1:0] second_left;
  logic signed [COORD_BITS-1:0] second_top;
  logic        [COORD_BITS-2:0] second_extent_x;
  logic        [COORD_BITS-2:0] second_extent_y;

  modport source (
    output valid, first_left, first_top, first_extent_x, first_extent_y,
           second_left, second_top, second_extent_x, second_extent_y,
    input  ready
  );
  modport sink (
    input  valid, first_left, first_top, first_extent_x, first_extent_y,
           second_left, second_top, second_extent_x, second_extent_y,
    output ready
  );
endinterface

interface rgd_out_if #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) ();
  logic                                valid;
  logic                                ready;
  logic [COORD_BITS-1:0]               gap_x;
  logic [COORD_BITS-1:0]               gap_y;
  logic [COORD_BITS+FRAC_BITS:0]       distance;

  modport source (output valid, gap_x, gap_y, distance, input ready);
  modport sink   (input valid, gap_x, gap_y, distance, output ready);
endinterface

### rtl/core/rgd_front.sv
// Front end: accepts rectangle pairs, forms per-axis gaps and their squares.
module rgd_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rgd_in_if.sink                    in_i,
  input  rgd_pkg::q_stat_t          q_stat_i,
  output logic                      push_o,
  output logic [COORD_BITS-1:0]     gap_x_o,
  output logic [COORD_BITS-1:0]     gap_y_o,
  output logic [2*COORD_BITS:0]     sum_o
);
  localparam int unsigned DW = COORD_BITS + 2;
  localparam int unsigned GW = COORD_BITS;
  localparam int unsigned QW = 2 * COORD_BITS;

  logic signed [DW-1:0] dx_lo, dx_hi, dy_lo, dy_hi;
  logic [GW-1:0] gx_d, gy_d;
  logic          v1_q, v2_q;
  logic [GW-1:0] gx1_q, gy1_q, gx2_q, gy2_q;
  logic [QW-1:0] sqx_q, sqy_q;
  logic          s2_adv;
  logic          in_take;

  // Gap is max(0, b - a - wa, a - b - wb); at most one term is positive.
  always_comb begin
    dx_hi = DW'(in_i.second_left) - DW'(in_i.first_left) - $signed(DW'(in_i.first_extent_x));
    dx_lo = DW'(in_i.first_left) - DW'(in_i.second_left) - $signed(DW'(in_i.second_extent_x));
    dy_hi = DW'(in_i.second_top) - DW'(in_i.first_top) - $signed(DW'(in_i.first_extent_y));
    dy_lo = DW'(in_i.first_top) - DW'(in_i.second_top) - $signed(DW'(in_i.second_extent_y));
    if (dx_hi > 0) begin
      gx_d = dx_hi[GW-1:0];
    end else if (dx_lo > 0) begin
      gx_d = dx_lo[GW-1:0];
    end else begin
      gx_d = '0;
    end
    if (dy_hi > 0) begin
      gy_d = dy_hi[GW-1:0];
    end else if (dy_lo > 0) begin
      gy_d = dy_lo[GW-1:0];
    end else begin
      gy_d = '0;
    end
  end

  assign push_o     = v2_q && !q_stat_i.full;
  assign s2_adv     = !v2_q || push_o;
  assign in_i.ready = !v1_q || s2_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        v1_q <= in_i.valid;
      end
      if (s2_adv) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      gx1_q <= gx_d;
      gy1_q <= gy_d;
    end
    if (s2_adv && v1_q) begin
      gx2_q <= gx1_q;
      gy2_q <= gy1_q;
      sqx_q <= QW'(gx1_q) * QW'(gx1_q);
      sqy_q <= QW'(gy1_q) * QW'(gy1_q);
    end
  end

  assign gap_x_o = gx2_q;
  assign gap_y_o = gy2_q;
  assign sum_o   = (QW + 1)'(sqx_q) + (QW + 1)'(sqy_q);

endmodule

### rtl/core/rgd_queue.sv
// Small word queue that decouples the gap front end from the root back end.
module rgd_queue #(
  parameter int unsigned W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [W-1:0]     push_data_i,
  input  logic             pop_i,
  output logic [W-1:0]     pop_data_o,
  output rgd_pkg::q_stat_t stat_o
);
  localparam int unsigned AW = rgd_pkg::QUEUE_AW;

  logic [W-1:0] mem_q [rgd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (AW + 1)'(rgd_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW + 1)'(rgd_pkg::QUEUE_DEPTH))
    else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/core/rgd_back.sv
// Back end: pipelined restoring square root, one root bit per stage.
module rgd_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rgd_pkg::q_stat_t          q_stat_i,
  input  logic [COORD_BITS-1:0]     gap_x_i,
  input  logic [COORD_BITS-1:0]     gap_y_i,
  input  logic [2*COORD_BITS:0]     sum_i,
  output logic                      pop_o,
  rgd_out_if.source                 out_o
);
  localparam int unsigned GW    = COORD_BITS;
  localparam int unsigned RB    = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned RW    = 2 * RB;
  localparam int unsigned REM_W = RB + 2;

  logic             en;
  logic [RB-1:0]    vld_q;
  logic [REM_W-1:0] rem_q  [RB];
  logic [RB-1:0]    root_q [RB];
  logic [RW-1:0]    rad_q  [RB];
  logic [GW-1:0]    gx_q   [RB];
  logic [GW-1:0]    gy_q   [RB];

  logic [REM_W-1:0] rem_in  [RB];
  logic [RB-1:0]    root_in [RB];
  logic [RW-1:0]    rad_in  [RB];
  logic [GW-1:0]    gx_in   [RB];
  logic [GW-1:0]    gy_in   [RB];
  logic [REM_W-1:0] rem_sh  [RB];
  logic [REM_W-1:0] trial   [RB];
  logic [REM_W-1:0] rem_d   [RB];
  logic [RB-1:0]    root_d  [RB];

  // Whole pipe moves together; last stage is the output register.
  assign en    = !vld_q[RB-1] || out_o.ready;
  assign pop_o = en && !q_stat_i.empty;

  always_comb begin
    for (int k = 0; k < RB; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        rad_in[k]  = RW'(sum_i) << (2 * FRAC_BITS);
        gx_in[k]   = gap_x_i;
        gy_in[k]   = gap_y_i;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        rad_in[k]  = rad_q[k-1];
        gx_in[k]   = gx_q[k-1];
        gy_in[k]   = gy_q[k-1];
      end
      rem_sh[k] = {rem_in[k][REM_W-3:0], rad_in[k][RW-1 -: 2]};
      trial[k]  = {root_in[k], 2'b01};
      if (rem_sh[k] >= trial[k]) begin
        rem_d[k]  = rem_sh[k] - trial[k];
        root_d[k] = {root_in[k][RB-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_sh[k];
        root_d[k] = {root_in[k][RB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[RB-2:0], !q_stat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < RB; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= {rad_in[k][RW-3:0], 2'b00};
        gx_q[k]   <= gx_in[k];
        gy_q[k]   <= gy_in[k];
      end
    end
  end

  assign out_o.valid    = vld_q[RB-1];
  assign out_o.distance = root_q[RB-1];
  assign out_o.gap_x    = gx_q[RB-1];
  assign out_o.gap_y    = gy_q[RB-1];

`ifndef ASSERT_OFF
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && en) |=> vld_q[1])
    else $error("word lost between root stages");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("root pipe moved while stalled");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.distance)))
    else $error("output word changed while stalled");
`endif

endmodule

### rtl/core/rect_gap_distance_top.sv
// Top level of the rectangle gap distance block.
//
// Usage:
//   in_i  (sink): one word is a pair of axis-aligned rectangles, each a signed
//         left and top edge and an unsigned width and height.
//   out_o (source): one word per input word, in order: the horizontal and
//         vertical gap (zero when the rectangles overlap or touch) and the
//         gap vector length, floor(sqrt(gx^2 + gy^2) * 2^FRAC_BITS).
// Structure: a two-stage front end (gaps, then squares) feeds a 4-word queue;
//   the back end is a square root pipeline of COORD_BITS+FRAC_BITS+1 stages,
//   one root bit per stage, whose last stage is the output register.
// Path: the accept loads the gap stage, then a word moves through the square
//   stage, the queue and the root stages in turn to the output register.
// Throughput: one word per cycle, with no bubbles while out_o.ready is high.
// Stall: a low out_o.ready with a word in the output register freezes the
//   root pipeline; the queue and front stages keep taking words until the
//   queue and both front stages are full, then in_i.ready drops.
// Reset: asynchronous, active low; clears all valid flags and queue
//   pointers, so no word is in flight afterward. No configuration.
module rect_gap_distance_top #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rgd_in_if.sink    in_i,
  rgd_out_if.source out_o
);
  // Queue word: gap_x, gap_y and the sum of squares.
  localparam int unsigned SW = 2 * COORD_BITS + 1;
  localparam int unsigned QW = 2 * COORD_BITS + SW;

  rgd_pkg::q_stat_t        q_stat;
  logic                    push, pop;
  logic [COORD_BITS-1:0]   f_gap_x, f_gap_y, b_gap_x, b_gap_y;
  logic [SW-1:0]           f_sum, b_sum;
  logic [QW-1:0]           q_wdata, q_rdata;

  rgd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .gap_x_o  (f_gap_x),
    .gap_y_o  (f_gap_y),
    .sum_o    (f_sum)
  );

  assign q_wdata = {f_gap_x, f_gap_y, f_sum};

  rgd_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_wdata),
    .pop_i       (pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  assign {b_gap_x, b_gap_y, b_sum} = q_rdata;

  rgd_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .gap_x_i  (b_gap_x),
    .gap_y_i  (b_gap_y),
    .sum_i    (b_sum),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
